>>> hdl/zsbf_pkg.sv
// Shared types and constants for the zlib stored-block framer.
`default_nettype none
package zsbf_pkg;

	localparam int unsigned QueueDepthDefault = 4;

	localparam logic [7:0]  ZlibCmf     = 8'h78;
	localparam logic [7:0]  ZlibFlg     = 8'h01;
	localparam logic [16:0] AdlerMod    = 17'd65521;
	localparam logic [15:0] BlockMax    = 16'hFFFF;

	// serializer phases of one queued entry
	localparam logic [3:0] PH_CMF  = 4'd0;
	localparam logic [3:0] PH_FLG  = 4'd1;
	localparam logic [3:0] PH_FIN  = 4'd2;
	localparam logic [3:0] PH_LENL = 4'd3;
	localparam logic [3:0] PH_LENH = 4'd4;
	localparam logic [3:0] PH_NLL  = 4'd5;
	localparam logic [3:0] PH_NLH  = 4'd6;
	localparam logic [3:0] PH_DATA = 4'd7;
	localparam logic [3:0] PH_SHH  = 4'd8;
	localparam logic [3:0] PH_SHL  = 4'd9;
	localparam logic [3:0] PH_SLH  = 4'd10;
	localparam logic [3:0] PH_SLL  = 4'd11;

	typedef struct packed {
		logic [7:0]  data;
		logic        hdr;
		logic        blk;
		logic        fin;
		logic [15:0] len;
		logic        last;
		logic [15:0] sum_high;
		logic [15:0] sum_low;
	} entry_t;

endpackage
`default_nettype wire

>>> hdl/zsbf_front.sv
// Front end: takes data beats, classifies them and keeps Adler-32 and block state.
`default_nettype none
module zsbf_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire logic            in_ready,
	input  wire logic [7:0]      data_byte,
	input  wire logic [31:0]     stream_length,
	output zsbf_pkg::entry_t     entry
);

	logic [31:0] bytes_taken_q;
	logic [15:0] block_left_q;
	logic [15:0] sum_low_q;
	logic [15:0] sum_high_q;

	logic [31:0] total;
	logic        gt;
	logic [31:0] diff;
	logic [31:0] remaining;
	logic        fin;
	logic [15:0] len;
	logic        last;
	logic        hdr;
	logic        blk;
	logic [16:0] sl_sum;
	logic [15:0] sl_new;
	logic [16:0] sh_sum;
	logic [15:0] sh_new;
	logic        take;

	assign take      = in_valid && in_ready;
	assign total     = (stream_length == 32'd0) ? 32'd1 : stream_length;
	assign hdr       = (bytes_taken_q == 32'd0);
	assign blk       = (block_left_q == 16'd0);
	assign gt        = (total > bytes_taken_q);
	assign diff      = total - bytes_taken_q;
	assign remaining = gt ? diff : 32'd1;
	assign fin       = (remaining[31:16] == 16'd0);
	assign len       = fin ? remaining[15:0] : zsbf_pkg::BlockMax;
	assign last      = !gt || (diff == 32'd1);

	assign sl_sum = {1'b0, sum_low_q} + {9'd0, data_byte};
	assign sl_new = (sl_sum >= zsbf_pkg::AdlerMod) ? 16'(sl_sum - zsbf_pkg::AdlerMod)
		: sl_sum[15:0];
	assign sh_sum = {1'b0, sum_high_q} + {1'b0, sl_new};
	assign sh_new = (sh_sum >= zsbf_pkg::AdlerMod) ? 16'(sh_sum - zsbf_pkg::AdlerMod)
		: sh_sum[15:0];

	always_comb begin
		entry.data     = data_byte;
		entry.hdr      = hdr;
		entry.blk      = blk;
		entry.fin      = fin;
		entry.len      = len;
		entry.last     = last;
		entry.sum_high = sh_new;
		entry.sum_low  = sl_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_taken_q <= '0;
			block_left_q  <= '0;
			sum_low_q     <= 16'd1;
			sum_high_q    <= '0;
		end else if (take) begin
			if (last) begin
				bytes_taken_q <= '0;
				block_left_q  <= '0;
				sum_low_q     <= 16'd1;
				sum_high_q    <= '0;
			end else begin
				bytes_taken_q <= bytes_taken_q + 32'd1;
				block_left_q  <= (blk ? len : block_left_q) - 16'd1;
				sum_low_q     <= sl_new;
				sum_high_q    <= sh_new;
			end
		end
	end

endmodule
`default_nettype wire

>>> hdl/zsbf_queue.sv
// Short queue of classified entries between front and back.
`default_nettype none
module zsbf_queue #(
	parameter int unsigned Depth = zsbf_pkg::QueueDepthDefault
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  zsbf_pkg::entry_t  push_entry,
	output logic              not_full,
	input  wire logic         pop,
	output logic              not_empty,
	output zsbf_pkg::entry_t  head
);

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] CntFull = CntW'(Depth);

	zsbf_pkg::entry_t slot_q [Depth];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;
	logic             do_push;
	logic             do_pop;

	assign not_full  = (count_q != CntFull);
	assign not_empty = (count_q != '0);
	assign do_push   = push && not_full;
	assign do_pop    = pop && not_empty;
	assign head      = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CntW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

endmodule
`default_nettype wire

>>> hdl/zsbf_back.sv
// Back end: expands each entry into its output bytes through an output register.
`default_nettype none
module zsbf_back (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         head_valid,
	input  zsbf_pkg::entry_t  head,
	output logic              pop,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [7:0]        m_tdata,
	output logic              m_tlast,
	output logic              m_tuser
);

	logic       active_q;
	logic [3:0] phase_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       end_q;

	logic [3:0] start_phase;
	logic [3:0] cur;
	logic [3:0] nxt;
	logic       at_end;
	logic       load;
	logic [7:0] cur_byte;

	assign start_phase = head.hdr ? zsbf_pkg::PH_CMF
		: (head.blk ? zsbf_pkg::PH_FIN : zsbf_pkg::PH_DATA);
	assign cur    = active_q ? phase_q : start_phase;
	assign at_end = ((cur == zsbf_pkg::PH_DATA) && !head.last) || (cur == zsbf_pkg::PH_SLL);
	assign load   = head_valid && (!valid_q || m_tready);
	assign pop    = load && at_end;

	always_comb begin
		case (cur)
			zsbf_pkg::PH_FLG:  nxt = head.blk ? zsbf_pkg::PH_FIN : zsbf_pkg::PH_DATA;
			default:           nxt = cur + 4'd1;
		endcase
	end

	always_comb begin
		case (cur)
			zsbf_pkg::PH_CMF:  cur_byte = zsbf_pkg::ZlibCmf;
			zsbf_pkg::PH_FLG:  cur_byte = zsbf_pkg::ZlibFlg;
			zsbf_pkg::PH_FIN:  cur_byte = {7'd0, head.fin};
			zsbf_pkg::PH_LENL: cur_byte = head.len[7:0];
			zsbf_pkg::PH_LENH: cur_byte = head.len[15:8];
			zsbf_pkg::PH_NLL:  cur_byte = ~head.len[7:0];
			zsbf_pkg::PH_NLH:  cur_byte = ~head.len[15:8];
			zsbf_pkg::PH_DATA: cur_byte = head.data;
			zsbf_pkg::PH_SHH:  cur_byte = head.sum_high[15:8];
			zsbf_pkg::PH_SHL:  cur_byte = head.sum_high[7:0];
			zsbf_pkg::PH_SLH:  cur_byte = head.sum_low[15:8];
			zsbf_pkg::PH_SLL:  cur_byte = head.sum_low[7:0];
			default:           cur_byte = head.data;
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= cur_byte;
			last_q <= at_end;
			end_q  <= (cur == zsbf_pkg::PH_SLL);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			phase_q  <= zsbf_pkg::PH_CMF;
			valid_q  <= 1'b0;
		end else begin
			if (load) begin
				valid_q  <= 1'b1;
				active_q <= !at_end;
				phase_q  <= nxt;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = byte_q;
	assign m_tlast  = last_q;
	assign m_tuser  = end_q;

endmodule
`default_nettype wire

>>> hdl/zlib_stored_block_framer.sv
// Top level of the zlib stored-block framer.
//
// Data bytes enter on s_tvalid/s_tready/s_tdata; zlib output leaves on
// m_tvalid/m_tready/m_tdata, with m_tlast on the last output beat caused by
// an input beat and m_tuser on the final Adler-32 byte of the stream.
// stream_length is written over APB at address 0; the user must write it
// only while the block is idle; the block does not enforce it. The first
// input beat of a stream yields 78 01, the stored-block header, the data
// byte; a beat that opens a block yields the 5-byte block header first;
// the last beat is followed by the 4-byte Adler-32, big-endian.
// Throughput: one output byte per cycle while the receiver is ready, so
// plain data beats flow at one per cycle; a beat with more than one output
// byte holds the output while the entry queue (QueueDepth entries) keeps
// taking input until it fills. Reset clears the queue, the output register
// and the stream state, and sets stream_length to 1. A stalled receiver
// holds the current output beat; s_tready drops once the queue is full.
`default_nettype none
module zlib_stored_block_framer #(
	parameter int unsigned QueueDepth = zsbf_pkg::QueueDepthDefault
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // [7:0] out_byte
	output logic             m_tlast,   // run_last
	output logic             m_tuser,   // [0] stream_end
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic [31:0]      stream_length_q;
	zsbf_pkg::entry_t front_entry;
	zsbf_pkg::entry_t head;
	logic             q_not_full;
	logic             q_not_empty;
	logic             pop;

	assign pready   = 1'b1;
	assign prdata   = (paddr[2] == 1'b0) ? stream_length_q : 32'd0;
	assign s_tready = q_not_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stream_length_q <= 32'd1;
		end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
			stream_length_q <= pwdata;
		end
	end

	zsbf_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_tvalid),
		.in_ready      (q_not_full),
		.data_byte     (s_tdata),
		.stream_length (stream_length_q),
		.entry         (front_entry)
	);

	zsbf_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (s_tvalid),
		.push_entry (front_entry),
		.not_full   (q_not_full),
		.pop        (pop),
		.not_empty  (q_not_empty),
		.head       (head)
	);

	zsbf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_not_empty),
		.head       (head),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser)
	);

endmodule
`default_nettype wire

>>> tb/zlib_stored_block_framer_test.sv
// Testbench for the zlib stored-block framer: directed and random byte streams checked beat by beat.
`timescale 1ns / 100ps
module zlib_stored_block_framer_test;

	localparam int unsigned CYCLE_LIMIT = 2_000_000;
	localparam logic [2:0]  REG_STREAM_LENGTH = 3'd0;
	localparam logic [7:0]  HDR_CMF = 8'h78;
	localparam logic [7:0]  HDR_FLG = 8'h01;
	localparam logic [7:0]  BFINAL_LAST = 8'h01;
	localparam logic [7:0]  BFINAL_MORE = 8'h00;
	localparam int unsigned ADLER_BASE = 65521;
	localparam int unsigned STORED_MAX = 65535;

	typedef struct {
		logic [7:0] data;
		logic       stream_end;
		logic       run_last;
	} zbeat_t;

	// tracks the framer state and the zlib beats still owed
	class zframe_tracker;
		logic [31:0] stream_len;
		logic [31:0] taken;
		logic [16:0] blk_left;
		int unsigned s_low;
		int unsigned s_high;
		zbeat_t      bytes_due[$];
		int          errors;

		function new();
			stream_len = 32'd1;
			errors = 0;
			restart();
		endfunction

		function void restart();
			taken = 32'd0;
			blk_left = 17'd0;
			s_low = 1;
			s_high = 0;
		endfunction

		function void due(logic [7:0] v, logic fin);
			zbeat_t bt;
			bt.data = v;
			bt.stream_end = fin;
			bt.run_last = 1'b0;
			bytes_due.push_back(bt);
		endfunction

		function void take_byte(logic [7:0] b);
			logic [31:0] total;
			logic [31:0] remaining;
			logic [31:0] len;
			logic [15:0] nlen;
			total = (stream_len == 32'd0) ? 32'd1 : stream_len;
			if (taken == 32'd0) begin
				due(HDR_CMF, 1'b0);
				due(HDR_FLG, 1'b0);
			end
			if (blk_left == 17'd0) begin
				remaining = (total > taken) ? total - taken : 32'd1;
				len = (remaining > STORED_MAX) ? STORED_MAX : remaining;
				nlen = ~len[15:0];
				due((remaining <= STORED_MAX) ? BFINAL_LAST : BFINAL_MORE, 1'b0);
				due(len[7:0], 1'b0);
				due(len[15:8], 1'b0);
				due(nlen[7:0], 1'b0);
				due(nlen[15:8], 1'b0);
				blk_left = len[16:0];
			end
			due(b, 1'b0);
			s_low = (s_low + b) % ADLER_BASE;
			s_high = (s_high + s_low) % ADLER_BASE;
			blk_left = blk_left - 17'd1;
			if ({1'b0, taken} + 33'd1 >= {1'b0, total}) begin
				due(s_high[15:8], 1'b0);
				due(s_high[7:0], 1'b0);
				due(s_low[15:8], 1'b0);
				due(s_low[7:0], 1'b1);
				restart();
			end else begin
				taken = taken + 32'd1;
			end
			bytes_due[bytes_due.size() - 1].run_last = 1'b1;
		endfunction

		function void match_beat(logic [7:0] d, logic e, logic l);
			zbeat_t want;
			if (bytes_due.size() == 0) begin
				$display("%0t: unexpected beat out_byte %02h stream_end %0b run_last %0b",
					$time, d, e, l);
				errors++;
				return;
			end
			want = bytes_due.pop_front();
			if (d !== want.data) begin
				$display("%0t: out_byte expected %02h got %02h", $time, want.data, d);
				errors++;
			end
			if (e !== want.stream_end) begin
				$display("%0t: stream_end expected %0b got %0b", $time, want.stream_end, e);
				errors++;
			end
			if (l !== want.run_last) begin
				$display("%0t: run_last expected %0b got %0b", $time, want.run_last, l);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] data_byte
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // [7:0] out_byte
	logic        m_tlast;
	logic        m_tuser;   // [0] stream_end
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	zframe_tracker sb;
	int unsigned   idle_odds;
	int unsigned   sent;
	int unsigned   rnd_base;
	int unsigned   cut;
	int unsigned   w;
	logic [31:0]   len;

	zlib_stored_block_framer u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("** zlib_stored_block_framer: FAILED **");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.match_beat(m_tdata, m_tuser, m_tlast);
	end

	// receiver backpressure
	initial begin
		@(posedge clk);
		forever begin
			if (idle_odds != 0 && $urandom_range(0, 99) < idle_odds) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
		end
	end

	task automatic push_byte(input logic [7:0] b);
		if (idle_odds != 0 && $urandom_range(0, 99) < idle_odds) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		sb.take_byte(b);
		sent++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.bytes_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [31:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_STREAM_LENGTH;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.stream_len = v;
	endtask

	initial begin
		sb = new();
		idle_odds = 0;
		sent = 0;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= 8'h00;
		m_tready <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= 3'd0;
		pwdata <= 32'd0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// length from reset, zero length, short stream
		push_byte(8'h00);
		drain();
		cfg_write(32'd0);
		push_byte(8'hFF);
		drain();
		idle_odds = 20;
		cfg_write(32'd3);
		push_byte(8'hFF);
		push_byte(8'h00);
		push_byte(8'hA5);
		drain();
		// max length, then lowered below what was taken
		cfg_write(32'hFFFF_FFFF);
		push_byte(8'h5A);
		push_byte(8'hFF);
		drain();
		cfg_write(32'd1);
		push_byte(8'h01);
		drain();
		// lowered after a block header, still above taken
		cfg_write(32'd8);
		repeat (3) push_byte(8'($urandom_range(0, 255)));
		drain();
		cfg_write(32'd5);
		repeat (2) push_byte(8'($urandom_range(0, 255)));
		drain();

		rnd_base = sent;
		while (sent - rnd_base < 360) begin
			if (sent - rnd_base >= 290)
				idle_odds = 0;
			else if ($urandom_range(0, 3) == 0)
				idle_odds = $urandom_range(0, 3) * 15;
			case ($urandom_range(0, 9))
				0: len = $urandom_range(STORED_MAX, 32'hFFFF_FFFF);
				1: len = $urandom_range(25, 60);
				2: len = 32'd0;
				default: len = $urandom_range(1, 24);
			endcase
			cfg_write(len);
			if (len > 300 || (len > 1 && $urandom_range(0, 3) == 0)) begin
				cut = $urandom_range(1, (len > 40) ? 40 : len - 1);
				repeat (cut) push_byte(8'($urandom_range(0, 255)));
				drain();
				if (len > 300 || $urandom_range(0, 1) == 0)
					cfg_write($urandom_range(0, cut));
				else
					cfg_write(cut + $urandom_range(1, 30));
			end
			do push_byte(8'($urandom_range(0, 255))); while (sb.taken != 32'd0);
			drain();
		end

		idle_odds = 0;
		s_tvalid <= 1'b0;
		for (w = 0; w < 20000 && sb.bytes_due.size() != 0; w++) @(posedge clk);
		repeat (16) @(posedge clk);
		if (sb.bytes_due.size() != 0) begin
			$display("%0t: %0d beats never arrived", $time, sb.bytes_due.size());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("** zlib_stored_block_framer: PASSED **");
		else
			$display("** zlib_stored_block_framer: FAILED **");
		$finish;
	end

endmodule

>>> zlib_stored_block_framer.f
hdl/zsbf_pkg.sv
hdl/zsbf_front.sv
hdl/zsbf_queue.sv
hdl/zsbf_back.sv
hdl/zlib_stored_block_framer.sv
tb/zlib_stored_block_framer_test.sv
